FILE: rtl/stepper_half_step_controller_top_macros.svh
// Assertion macros for the stepper half-step controller.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef STEPPER_HALF_STEP_CONTROLLER_TOP_MACROS_SVH
`define STEPPER_HALF_STEP_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define SHC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define SHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/shc_pkg.sv
// Shared types and constants for the stepper half-step controller.
// No dependencies.
`timescale 1ns / 1ps

package shc_pkg;

    localparam int unsigned ADDR_W = 4;

    localparam logic [1:0] REG_SPEED_STEP    = 2'd0;
    localparam logic [1:0] REG_FASTEST_BOUND = 2'd1;
    localparam logic [1:0] REG_SLOWEST_BOUND = 2'd2;

    localparam logic [9:0]  RST_SPEED_STEP    = 10'd100;
    localparam logic [11:0] RST_FASTEST_BOUND = 12'd100;
    localparam logic [11:0] RST_SLOWEST_BOUND = 12'd2000;
    localparam logic [11:0] RST_PERIOD        = 12'd1000;

    localparam logic [3:0] PAT_MAIN      = 4'b0001;
    localparam logic [3:0] PAT_SUB_RIGHT = 4'b0011;
    localparam logic [3:0] PAT_SUB_LEFT  = 4'b1001;

    localparam int unsigned BTN_PLAY   = 0;
    localparam int unsigned BTN_FASTER = 1;
    localparam int unsigned BTN_SLOWER = 2;
    localparam int unsigned BTN_LEFT   = 3;
    localparam int unsigned BTN_RIGHT  = 4;

    typedef struct packed {
        logic [9:0]  speed_step;
        logic [11:0] fastest_bound;
        logic [11:0] slowest_bound;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  coils;
        logic        motor_on;
        logic        turning_right;
        logic [11:0] period_ms;
    } t_status;

endpackage

FILE: rtl/shc_cfg.sv
// APB-style configuration registers: speed step and the two period bounds.
// Depends on shc_pkg.
`timescale 1ns / 1ps

module shc_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [shc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output shc_pkg::t_cfg              o_cfg
);

    logic [9:0]  r_speed_step;
    logic [11:0] r_fastest_bound;
    logic [11:0] r_slowest_bound;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_step    <= shc_pkg::RST_SPEED_STEP;
            r_fastest_bound <= shc_pkg::RST_FASTEST_BOUND;
            r_slowest_bound <= shc_pkg::RST_SLOWEST_BOUND;
        end else if (wr_en) begin
            unique case (reg_idx)
                shc_pkg::REG_SPEED_STEP:    r_speed_step    <= pwdata[9:0];
                shc_pkg::REG_FASTEST_BOUND: r_fastest_bound <= pwdata[11:0];
                shc_pkg::REG_SLOWEST_BOUND: r_slowest_bound <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            shc_pkg::REG_SPEED_STEP:    prdata = {22'd0, r_speed_step};
            shc_pkg::REG_FASTEST_BOUND: prdata = {20'd0, r_fastest_bound};
            shc_pkg::REG_SLOWEST_BOUND: prdata = {20'd0, r_slowest_bound};
            default:                    prdata = 32'd0;
        endcase
    end

    assign o_cfg.speed_step    = r_speed_step;
    assign o_cfg.fastest_bound = r_fastest_bound;
    assign o_cfg.slowest_bound = r_slowest_bound;

endmodule

FILE: rtl/shc_seq.sv
// Sequencer state: power, direction, period, coil patterns and half-step hold.
// Depends on shc_pkg and stepper_half_step_controller_top_macros.svh.
`timescale 1ns / 1ps
`include "stepper_half_step_controller_top_macros.svh"

module shc_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_action,
    input  logic [4:0]       i_buttons,
    input  shc_pkg::t_cfg    i_cfg,
    output shc_pkg::t_status o_next
);

    logic        r_power_on, n_power_on;
    logic        r_dir_right, n_dir_right;
    logic [11:0] r_period, n_period;
    logic [3:0]  r_main, n_main;
    logic [3:0]  r_rsub, n_rsub;
    logic [3:0]  r_lsub, n_lsub;
    logic        r_sub_next, n_sub_next;
    logic [10:0] r_hold, n_hold;
    logic        r_holding, n_holding;
    logic [3:0]  r_coil, n_coil;

    function automatic logic [3:0] rot_dir(input logic [3:0] p, input logic right);
        return right ? {p[2:0], p[3]} : {p[0], p[3:1]};
    endfunction

    always_comb begin
        logic [12:0] diff;
        logic [12:0] sum;
        logic [10:0] hold_dec;
        logic        keep;

        n_power_on  = r_power_on;
        n_dir_right = r_dir_right;
        n_period    = r_period;
        n_main      = r_main;
        n_rsub      = r_rsub;
        n_lsub      = r_lsub;
        n_sub_next  = r_sub_next;
        n_hold      = r_hold;
        n_holding   = r_holding;
        n_coil      = r_coil;

        diff     = {1'b0, r_period} - {3'd0, i_cfg.speed_step};
        sum      = {1'b0, r_period} + {3'd0, i_cfg.speed_step};
        hold_dec = (r_holding && (r_hold != 11'd0)) ? r_hold - 11'd1 : r_hold;
        keep     = r_holding && (hold_dec != 11'd0);

        if (i_action) begin
            if (i_buttons[shc_pkg::BTN_PLAY]) begin
                n_power_on = !r_power_on;
            end else if (i_buttons[shc_pkg::BTN_FASTER]) begin
                if (!diff[12] && (diff[11:0] > i_cfg.fastest_bound)) begin
                    n_period = diff[11:0];
                end
            end else if (i_buttons[shc_pkg::BTN_SLOWER]) begin
                if (sum < {1'b0, i_cfg.slowest_bound}) begin
                    n_period = sum[11:0];
                end
            end else if (i_buttons[shc_pkg::BTN_RIGHT]) begin
                n_dir_right = 1'b1;
                n_rsub      = shc_pkg::PAT_SUB_RIGHT;
                n_lsub      = shc_pkg::PAT_SUB_RIGHT;
                n_main      = shc_pkg::PAT_MAIN;
            end else if (i_buttons[shc_pkg::BTN_LEFT]) begin
                n_dir_right = 1'b0;
                n_rsub      = shc_pkg::PAT_SUB_RIGHT;
                n_lsub      = shc_pkg::PAT_SUB_LEFT;
                n_main      = shc_pkg::PAT_MAIN;
            end
        end else if (keep) begin
            n_hold = hold_dec;
        end else if (!r_power_on) begin
            n_holding = 1'b0;
            n_hold    = 11'd0;
            n_coil    = 4'd0;
        end else begin
            if (!r_sub_next) begin
                n_main = rot_dir(r_main, r_dir_right);
                n_coil = n_main;
            end else if (r_dir_right) begin
                n_rsub = rot_dir(r_rsub, r_dir_right);
                n_coil = n_rsub;
            end else begin
                n_lsub = rot_dir(r_lsub, r_dir_right);
                n_coil = n_lsub;
            end
            n_sub_next = !r_sub_next;
            n_hold     = r_period[11:1];
            n_holding  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_on  <= 1'b1;
            r_dir_right <= 1'b1;
            r_period    <= shc_pkg::RST_PERIOD;
            r_main      <= shc_pkg::PAT_MAIN;
            r_rsub      <= shc_pkg::PAT_SUB_RIGHT;
            r_lsub      <= shc_pkg::PAT_SUB_RIGHT;
            r_sub_next  <= 1'b0;
            r_hold      <= 11'd0;
            r_holding   <= 1'b0;
            r_coil      <= 4'd0;
        end else if (i_en) begin
            r_power_on  <= n_power_on;
            r_dir_right <= n_dir_right;
            r_period    <= n_period;
            r_main      <= n_main;
            r_rsub      <= n_rsub;
            r_lsub      <= n_lsub;
            r_sub_next  <= n_sub_next;
            r_hold      <= n_hold;
            r_holding   <= n_holding;
            r_coil      <= n_coil;
        end
    end

    assign o_next.coils         = n_coil;
    assign o_next.motor_on      = n_power_on;
    assign o_next.turning_right = n_dir_right;
    assign o_next.period_ms     = n_period;

    `SHC_ASSERT_NEXT(a_tick_keeps_period, i_clk, i_rst_n, i_en && !i_action,
        $stable(r_period), "tick changed the period")
    `SHC_ASSERT_NEXT(a_button_keeps_coils, i_clk, i_rst_n, i_en && i_action,
        $stable(r_coil), "button event changed the coils")
    `SHC_ASSERT_NEXT(a_idle_keeps_state, i_clk, i_rst_n, !i_en,
        $stable(r_power_on) && $stable(r_hold) && $stable(r_sub_next),
        "state moved without a transaction")
    `SHC_ASSERT_NOW(a_coil_shape, i_clk, i_rst_n, 1'b1,
        $countones(r_coil) <= 2, "more than two coils driven")

endmodule

FILE: rtl/stepper_half_step_controller_top.sv
// Top level of the stepper half-step controller: input and result registers.
// Depends on shc_pkg, shc_cfg and shc_seq.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+------------------------------------------
//   in       | i_in_valid / o_in_stall      | i_action, i_buttons
//   out      | o_out_valid / i_out_stall    | o_coils, o_motor_on, o_turning_right,
//            |                              | o_period_ms
//   config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One transaction per cycle while the result is not stalled.
// The state update is one pass of logic between the input and result registers.
// Synchronous active-low reset clears handshake and sequencer state; no clearing pass.
// A stalled result holds; the input register still takes a transaction while it is empty.
`timescale 1ns / 1ps

module stepper_half_step_controller_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic [4:0]                 i_buttons,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [3:0]                 o_coils,
    output logic                       o_motor_on,
    output logic                       o_turning_right,
    output logic [11:0]                o_period_ms,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [shc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    shc_pkg::t_cfg    cfg;
    shc_pkg::t_status next_status;

    logic             r_in_vld;
    logic             r_in_action;
    logic [4:0]       r_in_buttons;
    logic             r_out_vld;
    shc_pkg::t_status r_out;
    logic             advance;
    logic             in_acc;
    logic             step_en;

    assign advance    = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_in_vld && !advance;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign step_en    = advance && r_in_vld;

    shc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    shc_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (step_en),
        .i_action  (r_in_action),
        .i_buttons (r_in_buttons),
        .i_cfg     (cfg),
        .o_next    (next_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_action  <= i_action;
            r_in_buttons <= i_buttons;
        end
        if (step_en) begin
            r_out <= next_status;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_coils         = r_out.coils;
    assign o_motor_on      = r_out.motor_on;
    assign o_turning_right = r_out.turning_right;
    assign o_period_ms     = r_out.period_ms;

endmodule

FILE: tb/tb.sv
// Testbench for stepper_half_step_controller_top: directed table, then random ticks and buttons.
// Checks every result against its own model of the sequencer or a typed status; uses shc_pkg and the top.
// Registers are written over the APB-style port while no transaction is outstanding.
`timescale 1ns / 1ps

module tb;

    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_BUTTON = 1'b1;

    localparam logic [4:0] MASK_PLAY   = 5'(1 << shc_pkg::BTN_PLAY);
    localparam logic [4:0] MASK_FASTER = 5'(1 << shc_pkg::BTN_FASTER);
    localparam logic [4:0] MASK_SLOWER = 5'(1 << shc_pkg::BTN_SLOWER);
    localparam logic [4:0] MASK_LEFT   = 5'(1 << shc_pkg::BTN_LEFT);
    localparam logic [4:0] MASK_RIGHT  = 5'(1 << shc_pkg::BTN_RIGHT);

    localparam int unsigned RANDOM_ITEMS = 670;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic             action;
        logic [4:0]       buttons;
        logic [1:0]       reg_idx;
        logic [11:0]      value;
        bit               typed;
        shc_pkg::t_status status;
    } t_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_action;
    logic [4:0]                 i_buttons;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [3:0]                 o_coils;
    logic                       o_motor_on;
    logic                       o_turning_right;
    logic [11:0]                o_period_ms;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [shc_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    // sequencer copy
    logic        pwr_on;
    logic        dir_right;
    logic [11:0] per;
    logic [3:0]  main_pat;
    logic [3:0]  rsub_pat;
    logic [3:0]  lsub_pat;
    logic        sub_next;
    logic [10:0] hold_cnt;
    logic        hold_active;
    logic [3:0]  drive;

    logic [9:0]  step_cfg;
    logic [11:0] fast_bound;
    logic [11:0] slow_bound;

    shc_pkg::t_status pending_status[$];
    t_row             directed_rows[$];
    shc_pkg::t_status want_status;
    int               fails;
    int unsigned      send_idle_pct;
    int unsigned      stall_pct;

    stepper_half_step_controller_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_buttons      (i_buttons),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_coils        (o_coils),
        .o_motor_on     (o_motor_on),
        .o_turning_right(o_turning_right),
        .o_period_ms    (o_period_ms),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [3:0] turn(input logic [3:0] p);
        return dir_right ? {p[2:0], p[3]} : {p[0], p[3:1]};
    endfunction

    function automatic shc_pkg::t_status step_sequencer(input logic act, input logic [4:0] btn);
        if (act == ACT_BUTTON) begin
            if (btn[shc_pkg::BTN_PLAY]) begin
                pwr_on = !pwr_on;
            end else if (btn[shc_pkg::BTN_FASTER]) begin
                if (int'(per) - int'(step_cfg) > int'(fast_bound))
                    per = per - 12'(step_cfg);
            end else if (btn[shc_pkg::BTN_SLOWER]) begin
                if (int'(per) + int'(step_cfg) < int'(slow_bound))
                    per = per + 12'(step_cfg);
            end else if (btn[shc_pkg::BTN_RIGHT]) begin
                dir_right = 1'b1;
                rsub_pat  = shc_pkg::PAT_SUB_RIGHT;
                lsub_pat  = shc_pkg::PAT_SUB_RIGHT;
                main_pat  = shc_pkg::PAT_MAIN;
            end else if (btn[shc_pkg::BTN_LEFT]) begin
                dir_right = 1'b0;
                rsub_pat  = shc_pkg::PAT_SUB_RIGHT;
                lsub_pat  = shc_pkg::PAT_SUB_LEFT;
                main_pat  = shc_pkg::PAT_MAIN;
            end
        end else begin
            if (hold_active && hold_cnt != 0)
                hold_cnt = hold_cnt - 11'd1;
            if (!(hold_active && hold_cnt != 0)) begin
                if (!pwr_on) begin
                    hold_active = 1'b0;
                    hold_cnt    = '0;
                    drive       = '0;
                end else begin
                    if (!sub_next) begin
                        main_pat = turn(main_pat);
                        drive    = main_pat;
                    end else if (dir_right) begin
                        rsub_pat = turn(rsub_pat);
                        drive    = rsub_pat;
                    end else begin
                        lsub_pat = turn(lsub_pat);
                        drive    = lsub_pat;
                    end
                    sub_next    = !sub_next;
                    hold_cnt    = per[11:1];
                    hold_active = 1'b1;
                end
            end
        end
        return '{drive, pwr_on, dir_right, per};
    endfunction

    task automatic row_item(input logic act, input logic [4:0] btn);
        t_row r;
        r.kind    = ROW_ITEM;
        r.action  = act;
        r.buttons = btn;
        r.reg_idx = '0;
        r.value   = '0;
        r.typed   = 1'b0;
        r.status  = '0;
        directed_rows.push_back(r);
    endtask

    task automatic row_typed(input logic act, input logic [4:0] btn, input logic [3:0] coils,
                             input logic on, input logic right, input logic [11:0] period);
        t_row r;
        r.kind    = ROW_ITEM;
        r.action  = act;
        r.buttons = btn;
        r.reg_idx = '0;
        r.value   = '0;
        r.typed   = 1'b1;
        r.status  = '{coils, on, right, period};
        directed_rows.push_back(r);
    endtask

    task automatic row_reg(input logic [1:0] idx, input logic [11:0] value);
        t_row r;
        r.kind    = ROW_REG;
        r.action  = ACT_TICK;
        r.buttons = '0;
        r.reg_idx = idx;
        r.value   = value;
        r.typed   = 1'b0;
        r.status  = '0;
        directed_rows.push_back(r);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            shc_pkg::REG_SPEED_STEP:    step_cfg   = value[9:0];
            shc_pkg::REG_FASTEST_BOUND: fast_bound = value;
            shc_pkg::REG_SLOWEST_BOUND: slow_bound = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic transfer_item(input logic act, input logic [4:0] btn,
                                 input bit typed, input shc_pkg::t_status typed_status);
        shc_pkg::t_status got;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_buttons  <= btn;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = step_sequencer(act, btn);
        pending_status.push_back(typed ? typed_status : got);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_status.size() == 0) begin
                $error("result with no transaction outstanding");
                fails++;
            end else begin
                want_status = pending_status.pop_front();
                if (o_coils !== want_status.coils) begin
                    $error("coils: expected %0h, got %0h", want_status.coils, o_coils);
                    fails++;
                end
                if (o_motor_on !== want_status.motor_on) begin
                    $error("motor_on: expected %0d, got %0d", want_status.motor_on, o_motor_on);
                    fails++;
                end
                if (o_turning_right !== want_status.turning_right) begin
                    $error("turning_right: expected %0d, got %0d",
                           want_status.turning_right, o_turning_right);
                    fails++;
                end
                if (o_period_ms !== want_status.period_ms) begin
                    $error("period_ms: expected %0d, got %0d", want_status.period_ms, o_period_ms);
                    fails++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("FAIL stepper_half_step_controller_top");
        $finish;
    end

    initial begin
        logic        act;
        logic [4:0]  btn;
        int unsigned sel;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = ACT_TICK;
        i_buttons     = '0;
        i_out_stall   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        fails         = 0;
        send_idle_pct = 0;
        stall_pct     = 0;

        pwr_on      = 1'b1;
        dir_right   = 1'b1;
        per         = shc_pkg::RST_PERIOD;
        main_pat    = shc_pkg::PAT_MAIN;
        rsub_pat    = shc_pkg::PAT_SUB_RIGHT;
        lsub_pat    = shc_pkg::PAT_SUB_RIGHT;
        sub_next    = 1'b0;
        hold_cnt    = '0;
        hold_active = 1'b0;
        drive       = '0;
        step_cfg    = shc_pkg::RST_SPEED_STEP;
        fast_bound  = shc_pkg::RST_FASTEST_BOUND;
        slow_bound  = shc_pkg::RST_SLOWEST_BOUND;

        row_typed(ACT_BUTTON, 5'b00000, 4'b0000, 1'b1, 1'b1, shc_pkg::RST_PERIOD);
        row_typed(ACT_BUTTON, MASK_FASTER, 4'b0000, 1'b1, 1'b1, 12'd900);
        row_typed(ACT_BUTTON, MASK_SLOWER, 4'b0000, 1'b1, 1'b1, shc_pkg::RST_PERIOD);
        row_typed(ACT_BUTTON, 5'b11111, 4'b0000, 1'b0, 1'b1, shc_pkg::RST_PERIOD);
        row_typed(ACT_BUTTON, MASK_PLAY, 4'b0000, 1'b1, 1'b1, shc_pkg::RST_PERIOD);
        row_typed(ACT_BUTTON, MASK_LEFT, 4'b0000, 1'b1, 1'b0, shc_pkg::RST_PERIOD);
        row_typed(ACT_BUTTON, MASK_LEFT | MASK_RIGHT, 4'b0000, 1'b1, 1'b1,
                  shc_pkg::RST_PERIOD);
        row_item(ACT_BUTTON, MASK_FASTER | MASK_SLOWER);
        row_reg(shc_pkg::REG_SPEED_STEP, 12'd1000);
        row_reg(shc_pkg::REG_FASTEST_BOUND, 12'd4095);
        row_reg(shc_pkg::REG_SLOWEST_BOUND, 12'd4095);
        row_item(ACT_BUTTON, MASK_FASTER);
        row_item(ACT_BUTTON, MASK_SLOWER | MASK_LEFT);
        row_reg(shc_pkg::REG_SPEED_STEP, 12'd999);
        row_reg(shc_pkg::REG_FASTEST_BOUND, 12'd0);
        row_reg(shc_pkg::REG_SLOWEST_BOUND, 12'd0);
        row_item(ACT_BUTTON, MASK_SLOWER);
        row_item(ACT_BUTTON, MASK_FASTER);
        row_item(ACT_BUTTON, MASK_FASTER | MASK_RIGHT);
        row_reg(shc_pkg::REG_SPEED_STEP, 12'd1);
        row_item(ACT_BUTTON, MASK_FASTER);
        row_item(ACT_TICK, 5'b10101);
        row_item(ACT_TICK, 5'b01010);
        row_item(ACT_BUTTON, MASK_LEFT);
        row_item(ACT_TICK, 5'b00000);
        row_item(ACT_TICK, 5'b11111);
        row_reg(shc_pkg::REG_SLOWEST_BOUND, 12'd12);
        row_item(ACT_BUTTON, MASK_SLOWER);
        row_item(ACT_BUTTON, MASK_SLOWER);
        row_item(ACT_TICK, 5'b00000);
        row_item(ACT_BUTTON, MASK_PLAY);
        row_item(ACT_TICK, 5'b00000);
        row_item(ACT_BUTTON, MASK_PLAY | MASK_SLOWER);
        row_item(ACT_TICK, 5'b00000);
        row_item(ACT_TICK, 5'b00000);
        row_item(ACT_BUTTON, MASK_RIGHT);
        row_item(ACT_TICK, 5'b00000);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_REG) begin
                wait_idle();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].value);
            end else begin
                transfer_item(directed_rows[r].action, directed_rows[r].buttons,
                              directed_rows[r].typed, directed_rows[r].status);
            end
        end
        wait_idle();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 62 : 0;
            stall_pct     = (ph == 0) ? 62 : (ph == 1) ? 25 : 0;
            write_reg(shc_pkg::REG_SPEED_STEP, 12'($urandom_range(1, 4)));
            write_reg(shc_pkg::REG_FASTEST_BOUND, 12'($urandom_range(0, 2)));
            write_reg(shc_pkg::REG_SLOWEST_BOUND, 12'($urandom_range(8, 40)));
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                act = ($urandom_range(0, 9) >= 7) ? ACT_BUTTON : ACT_TICK;
                btn = 5'($urandom);
                if (act == ACT_BUTTON) begin
                    sel = $urandom_range(0, 9);
                    case (sel)
                        0:       btn = 5'($urandom);
                        1:       btn = 5'($urandom) | MASK_PLAY;
                        2, 3, 4: btn = (5'($urandom) & ~MASK_PLAY) | MASK_FASTER;
                        5, 6, 7: btn = (5'($urandom) & (MASK_LEFT | MASK_RIGHT)) | MASK_SLOWER;
                        8:       btn = (5'($urandom) & MASK_LEFT) | MASK_RIGHT;
                        default: btn = 5'($urandom) & MASK_LEFT;
                    endcase
                end
                transfer_item(act, btn, 1'b0, '0);
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (fails == 0) begin
            $display("PASS stepper_half_step_controller_top");
        end else begin
            $display("FAIL stepper_half_step_controller_top");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/shc_pkg.sv
rtl/shc_cfg.sv
rtl/shc_seq.sv
rtl/stepper_half_step_controller_top.sv
tb/tb.sv
